@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while in reset
`define DSPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dspg assertion failed");

// Next-cycle implication, quiet while in reset
`define DSPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dspg assertion failed");

// Next-cycle implication that also holds through reset
`define DSPG_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dspg assertion failed");

`endif

@@ rtl/dspg_pkg.sv @@
package dspg_pkg;

  // Default sizing
  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int MAX_FREQ_DEF      = 5000;

  // Fixed field widths
  localparam int OP_W   = 3;
  localparam int FREQ_W = 16;
  localparam int CLK_W  = 20;
  localparam int CFG_IDX_W = 1;
  localparam int CUR_FREQ_W = 13;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_START  = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
  localparam logic [OP_W-1:0] OP_DIR    = 3'd4;
  localparam logic [OP_W-1:0] OP_ENABLE = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_LOW     = 1'b1;

  // Frequency constants
  localparam logic [FREQ_W-1:0] DEFAULT_FREQ = 16'd1000;
  localparam logic [FREQ_W-1:0] MIN_FREQ     = 16'd2;
  localparam logic [CLK_W-1:0]  CLOCK_RATE_RST = 20'd125000;

  // Divider steps: one quotient bit per cycle
  localparam int DIV_STEPS = CLK_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              motor;
    logic [FREQ_W-1:0] freq_value;
    logic              flag;
  } in_item_t;

  typedef struct packed {
    logic                  step_a;
    logic                  step_b;
    logic                  dir_a;
    logic                  dir_b;
    logic                  en_pin_a;
    logic                  en_pin_b;
    logic                  running_a;
    logic                  running_b;
    logic [CUR_FREQ_W-1:0] current_freq;
  } out_item_t;

  // Divider handshake towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/dspg_div.sv @@
// Restoring divider, one quotient bit per cycle
module dspg_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dspg_pkg::CLK_W-1:0]   dividend,
  input  logic [dspg_pkg::FREQ_W-1:0]  divisor,
  output dspg_pkg::div_stat_t          stat,
  output logic [dspg_pkg::CLK_W-1:0]   quotient
);

  logic [dspg_pkg::CLK_W-1:0]     dvd_r;
  logic [dspg_pkg::FREQ_W-1:0]    dsr_r;
  logic [dspg_pkg::FREQ_W-1:0]    rem_r;
  logic [dspg_pkg::CLK_W-1:0]     quo_r;
  logic [dspg_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [dspg_pkg::FREQ_W:0] rem_sh;
  logic [dspg_pkg::FREQ_W:0] rem_sub;
  logic                      ge;

  // Shift in next dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem_r, dvd_r[dspg_pkg::CLK_W-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_sub = rem_sh - {1'b0, dsr_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == dspg_pkg::DIV_CNT_W'(dspg_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[dspg_pkg::CLK_W-2:0], 1'b0};
      rem_r <= ge ? rem_sub[dspg_pkg::FREQ_W-1:0] : rem_sh[dspg_pkg::FREQ_W-1:0];
      quo_r <= {quo_r[dspg_pkg::CLK_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ rtl/dual_step_pulse_generator_top.sv @@
// Channel   Dir  Handshake          Payload
// in        in   in_valid/in_stall  in_data   (op, motor, freq_value, flag)
// out       out  out_valid/out_stall out_data (pins, run flags, current_freq)
// cfg       in   cfg_we             cfg_index, cfg_wdata
//
// Tick, stop, direction and enable beats go straight to the emit state; start and a
// frequency change first run the 20-step shared divider (one bit a cycle).
// One beat is worked on at a time; in_stall is high until the result is loaded.
// A finished result waits in the output register while the next beat is taken.
// rst_n is synchronous: motors stopped, clockwise, disabled, clock rate 125 kHz.
module dual_step_pulse_generator_top #(
  parameter int COUNTER_WIDTH = dspg_pkg::COUNTER_WIDTH_DEF,
  parameter int MAX_FREQ      = dspg_pkg::MAX_FREQ_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dspg_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dspg_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [dspg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dspg_pkg::CLK_W-1:0]      cfg_wdata
);

  localparam int CW    = COUNTER_WIDTH;
  localparam int PER_W = CW + 1;
  localparam int EXT_W = (PER_W > dspg_pkg::CLK_W) ? PER_W : dspg_pkg::CLK_W;
  localparam logic [dspg_pkg::FREQ_W-1:0] FMAX = dspg_pkg::FREQ_W'(MAX_FREQ);

  // Per-motor state
  logic [PER_W-1:0]            period_r    [2];
  logic [CW-1:0]               compare_r   [2];
  logic [CW-1:0]               count_r     [2];
  logic [dspg_pkg::FREQ_W-1:0] last_freq_r [2];
  logic [1:0]                  run_r;
  logic [1:0]                  dir_r;
  logic [1:0]                  en_r;

  // Configuration
  logic [dspg_pkg::CLK_W-1:0] clock_rate_r;
  logic                       en_low_r;

  // Sequencer
  dspg_pkg::state_t            state_r, state_nxt;
  logic                        cmd_motor_r;
  logic [dspg_pkg::FREQ_W-1:0] cmd_freq_r;
  logic                        out_valid_r;
  dspg_pkg::out_item_t         out_data_r;

  logic                        in_acc;
  logic                        need_div;
  logic                        emit;
  logic [dspg_pkg::FREQ_W-1:0] f_sel;
  logic [dspg_pkg::FREQ_W-1:0] f_clamp;

  dspg_pkg::div_stat_t         div_stat;
  logic [dspg_pkg::CLK_W-1:0]  div_quo;

  logic [EXT_W-1:0]            q_ext;
  logic [EXT_W-1:0]            lim_ext;
  logic [PER_W-1:0]            per_sat;
  logic [CW-1:0]               tick_cnt [2];
  logic [PER_W-1:0]            cnt_inc  [2];

  // Frequency selection and clamp
  always_comb begin
    f_sel = in_data.freq_value;
    if (in_data.op == dspg_pkg::OP_START && in_data.freq_value == '0) begin
      f_sel = dspg_pkg::DEFAULT_FREQ;
    end
    f_clamp = f_sel;
    if (f_clamp < dspg_pkg::MIN_FREQ) begin
      f_clamp = dspg_pkg::MIN_FREQ;
    end
    if (f_clamp > FMAX) begin
      f_clamp = FMAX;
    end
    need_div = (in_data.op == dspg_pkg::OP_START) ||
               (in_data.op == dspg_pkg::OP_UPDATE && in_data.freq_value != '0 &&
                f_clamp != last_freq_r[in_data.motor]);
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    in_acc    = 1'b0;
    emit      = 1'b0;
    case (state_r)
      dspg_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_acc    = 1'b1;
          state_nxt = need_div ? dspg_pkg::ST_DIV : dspg_pkg::ST_EMIT;
        end
      end
      dspg_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = dspg_pkg::ST_EMIT;
        end
      end
      dspg_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          emit      = 1'b1;
          state_nxt = dspg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dspg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dspg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Shared divider: clock_rate / frequency
  dspg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && need_div),
    .dividend (clock_rate_r),
    .divisor  (f_clamp),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Period saturation to 2 .. 2^CW
  always_comb begin
    q_ext   = EXT_W'(div_quo);
    lim_ext = EXT_W'(1) << CW;
    if (q_ext > lim_ext) begin
      q_ext = lim_ext;
    end
    if (q_ext < EXT_W'(2)) begin
      q_ext = EXT_W'(2);
    end
    per_sat = q_ext[PER_W-1:0];
  end

  // Tick: wrap counters at period
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      cnt_inc[k]  = {1'b0, count_r[k]} + PER_W'(1);
      tick_cnt[k] = (cnt_inc[k] >= period_r[k]) ? '0 : cnt_inc[k][CW-1:0];
    end
  end

  // Command latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_motor_r <= in_data.motor;
      cmd_freq_r  <= f_clamp;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= dspg_pkg::CLOCK_RATE_RST;
      en_low_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dspg_pkg::CFG_CLOCK_RATE: clock_rate_r <= cfg_wdata;
        dspg_pkg::CFG_EN_LOW:     en_low_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Motor state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2; k++) begin
        period_r[k]    <= PER_W'(2);
        compare_r[k]   <= '0;
        count_r[k]     <= '0;
        last_freq_r[k] <= '0;
      end
      run_r <= 2'b00;
      dir_r <= 2'b11;
      en_r  <= 2'b00;
    end else if (state_r == dspg_pkg::ST_DIV && div_stat.done) begin
      period_r[cmd_motor_r]    <= per_sat;
      compare_r[cmd_motor_r]   <= per_sat[PER_W-1:1];
      count_r[cmd_motor_r]     <= '0;
      run_r[cmd_motor_r]       <= 1'b1;
      last_freq_r[cmd_motor_r] <= cmd_freq_r;
    end else if (in_acc && !need_div) begin
      case (in_data.op)
        dspg_pkg::OP_TICK: begin
          for (int k = 0; k < 2; k++) begin
            if (run_r[k]) begin
              count_r[k] <= tick_cnt[k];
            end
          end
        end
        dspg_pkg::OP_UPDATE: begin
          // zero stops; unchanged frequency leaves all as is
          if (in_data.freq_value == '0) begin
            run_r[in_data.motor]       <= 1'b0;
            last_freq_r[in_data.motor] <= '0;
          end
        end
        dspg_pkg::OP_STOP: begin
          run_r[in_data.motor]       <= 1'b0;
          last_freq_r[in_data.motor] <= '0;
        end
        dspg_pkg::OP_DIR:    dir_r[in_data.motor] <= in_data.flag;
        dspg_pkg::OP_ENABLE: en_r[in_data.motor]  <= in_data.flag;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.step_a       <= run_r[0] && (count_r[0] < compare_r[0]);
      out_data_r.step_b       <= run_r[1] && (count_r[1] < compare_r[1]);
      out_data_r.dir_a        <= dir_r[0];
      out_data_r.dir_b        <= dir_r[1];
      out_data_r.en_pin_a     <= en_r[0] ^ en_low_r;
      out_data_r.en_pin_b     <= en_r[1] ^ en_low_r;
      out_data_r.running_a    <= run_r[0];
      out_data_r.running_b    <= run_r[1];
      out_data_r.current_freq <= last_freq_r[cmd_motor_r][dspg_pkg::CUR_FREQ_W-1:0];
    end
  end

  assign in_stall  = (state_r != dspg_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/dspg_checker.sv @@
`include "assert_macros.svh"

// Port-level checks on the pulse generator
module dspg_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input dspg_pkg::out_item_t out_data
);

  // a held result keeps its beat
  `DSPG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // one beat in work at a time
  `DSPG_ASSERT_NXT(a_busy_after_acc, clk, rst_n, in_valid && !in_stall, in_stall)

  // a stopped motor gives no step
  `DSPG_ASSERT_IMP(a_step_a_run, clk, rst_n, out_valid && !out_data.running_a, !out_data.step_a)
  `DSPG_ASSERT_IMP(a_step_b_run, clk, rst_n, out_valid && !out_data.running_b, !out_data.step_b)

  // reset empties the output register
  `DSPG_ASSERT_NXT_ALL(a_rst_out, clk, !rst_n, !out_valid)

endmodule

bind dual_step_pulse_generator_top dspg_checker u_dspg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
